/* hdl/lcdns_pkg.sv */
`default_nettype none

package lcdns_pkg;

  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned InitEntries       = 10;
  localparam int unsigned InitIdxW          = 4;

  localparam logic [15:0] PowerWaitUs  = 16'd20000;
  localparam logic [15:0] Pre1WaitUs   = 16'd5000;
  localparam logic [15:0] Pre2WaitUs   = 16'd150;
  localparam logic [15:0] Pre4WaitUs   = 16'd50;
  localparam logic [3:0]  NibWake      = 4'h3;
  localparam logic [3:0]  NibFourBit   = 4'h2;
  localparam logic [7:0]  CmdClear     = 8'h01;
  localparam logic [7:0]  CmdHome      = 8'h02;
  localparam logic [7:0]  CmdFuncSet   = 8'h28;
  localparam logic [7:0]  CmdDispOff   = 8'h08;
  localparam logic [7:0]  CmdEntryMode = 8'h06;
  localparam logic [7:0]  CmdDispOn    = 8'h0C;

  localparam logic [9:0]  PulseReset  = 10'd1;
  localparam logic [9:0]  SettleReset = 10'd50;
  localparam logic [15:0] LongReset   = 16'd2000;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_CMD    = 2'd1,
    MODE_DATA   = 2'd2,
    MODE_CURSOR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_PULSE  = 2'd0,
    CFG_SETTLE = 2'd1,
    CFG_LONG   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ENT_POWER  = 2'd0,
    ENT_NIBBLE = 2'd1,
    ENT_BYTE   = 2'd2
  } ent_kind_e;

  typedef struct packed {
    ent_kind_e   kind;
    logic        rs;
    logic [7:0]  value;
    logic [15:0] hold_us;
    logic        last;
  } entry_t;

  function automatic entry_t init_entry(input logic [InitIdxW-1:0] idx);
    entry_t e;
    e.kind    = ENT_BYTE;
    e.rs      = 1'b0;
    e.value   = 8'h00;
    e.hold_us = 16'd0;
    e.last    = 1'b0;
    unique case (idx)
      4'd0: begin
        e.kind    = ENT_POWER;
        e.hold_us = PowerWaitUs;
      end
      4'd1: begin
        e.kind    = ENT_NIBBLE;
        e.value   = {4'h0, NibWake};
        e.hold_us = Pre1WaitUs;
      end
      4'd2, 4'd3: begin
        e.kind    = ENT_NIBBLE;
        e.value   = {4'h0, NibWake};
        e.hold_us = Pre2WaitUs;
      end
      4'd4: begin
        e.kind    = ENT_NIBBLE;
        e.value   = {4'h0, NibFourBit};
        e.hold_us = Pre4WaitUs;
      end
      4'd5: e.value = CmdFuncSet;
      4'd6: e.value = CmdDispOff;
      4'd7: e.value = CmdClear;
      4'd8: e.value = CmdEntryMode;
      4'd9: begin
        e.value = CmdDispOn;
        e.last  = 1'b1;
      end
      default: begin
        e.kind    = ENT_POWER;
        e.hold_us = PowerWaitUs;
      end
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

/* hdl/lcdns_req_if.sv */
`default_nettype none

interface lcdns_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] byte_value;
  logic       row;
  logic [5:0] col;

  modport source (output valid, mode, byte_value, row, col, input ready);
  modport sink   (input valid, mode, byte_value, row, col, output ready);
endinterface

`default_nettype wire

/* hdl/lcdns_step_if.sv */
`default_nettype none

interface lcdns_step_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic        enable;
  logic [3:0]  nibble;
  logic [15:0] wait_us;
  logic        last;

  modport source (output valid, reg_select, enable, nibble, wait_us, last, input ready);
  modport sink   (input valid, reg_select, enable, nibble, wait_us, last, output ready);
endinterface

`default_nettype wire

/* hdl/char_lcd_nibble_sequencer_top.sv */
// A request's first pin step passes through the step queue, the current-entry register
// and the output register. One pin step per cycle while the step interface is ready; the
// step sequencer in the back end splits a command, character, set-cursor or init into steps.
// Requests are accepted while the step queue has room; init holds the input until its
// ten queue entries are in.
// Reset: queue and sequencer empty, timings back to 1, 50 and 2000 us.
`default_nettype none

module char_lcd_nibble_sequencer_top
  import lcdns_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  lcdns_req_if.sink        req_i,
  lcdns_step_if.source     stp_o
);

  entry_t push_entry, head_entry;
  logic   push, pop, full, head_valid;

  lcdns_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_i),
    .q_full_i  (full),
    .q_entry_o (push_entry),
    .q_push_o  (push)
  );

  lcdns_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .entry_o (head_entry)
  );

  lcdns_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_valid_i  (head_valid),
    .q_entry_i  (head_entry),
    .q_pop_o    (pop),
    .stp        (stp_o)
  );

endmodule

`default_nettype wire

/* hdl/lcdns_front.sv */
`default_nettype none

module lcdns_front
  import lcdns_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lcdns_req_if.sink   req,
  input  wire logic   q_full_i,
  output entry_t      q_entry_o,
  output logic        q_push_o
);

  logic [InitIdxW-1:0] init_cnt_q, init_cnt_d;
  logic                accept;

  // init expands into one queue entry per cycle while the queue is not full; first one goes with the accepted beat
  assign req.ready = (init_cnt_q == '0) && !q_full_i;
  assign accept    = req.valid && req.ready;

  always_comb begin
    init_cnt_d = init_cnt_q;
    q_push_o   = 1'b0;
    q_entry_o  = init_entry(init_cnt_q);
    if (init_cnt_q != '0) begin
      if (!q_full_i) begin
        q_push_o = 1'b1;
        if (init_cnt_q == InitIdxW'(InitEntries - 1)) begin
          init_cnt_d = '0;
        end else begin
          init_cnt_d = init_cnt_q + 1'b1;
        end
      end
    end else if (accept) begin
      q_push_o         = 1'b1;
      q_entry_o.kind   = ENT_BYTE;
      q_entry_o.rs     = 1'b0;
      q_entry_o.hold_us = 16'd0;
      q_entry_o.last   = 1'b1;
      q_entry_o.value  = req.byte_value;
      unique case (mode_e'(req.mode))
        MODE_INIT: begin
          q_entry_o  = init_entry('0);
          init_cnt_d = InitIdxW'(1);
        end
        MODE_CMD:    q_entry_o.rs = 1'b0;
        MODE_DATA:   q_entry_o.rs = 1'b1;
        MODE_CURSOR: q_entry_o.value = {1'b1, req.row, req.col};
        default:     q_entry_o.rs = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
    end else begin
      init_cnt_q <= init_cnt_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/lcdns_fifo.sv */
`default_nettype none

module lcdns_fifo
  import lcdns_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        valid_o,
  output entry_t      entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/lcdns_back.sv */
`default_nettype none

module lcdns_back
  import lcdns_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        q_valid_i,
  input  wire entry_t      q_entry_i,
  output logic             q_pop_o,
  lcdns_step_if.source     stp
);

  logic [9:0]  pulse_q, settle_q;
  logic [15:0] long_q;

  entry_t      cur_q;
  logic        cur_valid_q;
  logic [2:0]  step_q;

  logic        out_valid_q;
  logic        out_rs_q, out_en_q, out_last_q;
  logic [3:0]  out_nib_q;
  logic [15:0] out_wait_q;

  logic        advance, final_step, load;
  logic [2:0]  final_idx;
  logic        rs_d, en_d, last_d;
  logic [3:0]  nib_d;
  logic [15:0] wait_d;
  logic [15:0] pulse_w, settle_w;

  assign pulse_w  = {6'd0, pulse_q};
  assign settle_w = {6'd0, settle_q};

  always_comb begin
    unique case (cur_q.kind)
      ENT_POWER:  final_idx = 3'd0;
      ENT_NIBBLE: final_idx = 3'd2;
      ENT_BYTE:   final_idx = 3'd4;
      default:    final_idx = 3'd0;
    endcase
  end

  assign advance    = cur_valid_q && (!out_valid_q || stp.ready);
  assign final_step = (step_q == final_idx);
  assign load       = q_valid_i && (!cur_valid_q || (advance && final_step));
  assign q_pop_o    = load;

  always_comb begin
    rs_d   = cur_q.rs;
    last_d = cur_q.last && final_step;
    en_d   = 1'b0;
    nib_d  = cur_q.value[3:0];
    wait_d = settle_w;
    unique case (cur_q.kind)
      ENT_POWER: begin
        rs_d   = 1'b0;
        nib_d  = 4'h0;
        wait_d = cur_q.hold_us;
      end
      ENT_NIBBLE: begin
        en_d = (step_q == 3'd0);
        if (step_q == 3'd0) begin
          wait_d = pulse_w;
        end else if (step_q == 3'd2) begin
          wait_d = cur_q.hold_us;
        end
      end
      ENT_BYTE: begin
        // high nibble strobe and settle, low nibble strobe and settle, then hold
        nib_d = (step_q < 3'd2) ? cur_q.value[7:4] : cur_q.value[3:0];
        en_d  = !step_q[0] && (step_q != 3'd4);
        if (en_d) begin
          wait_d = pulse_w;
        end else if (step_q == 3'd4 && !cur_q.rs &&
                     (cur_q.value == CmdClear || cur_q.value == CmdHome)) begin
          wait_d = long_q;
        end
      end
      default: begin
        nib_d = 4'h0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q  <= PulseReset;
      settle_q <= SettleReset;
      long_q   <= LongReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PULSE) begin
        pulse_q <= cfg_data_i[9:0];
      end else if (cfg_idx_i == CFG_SETTLE) begin
        settle_q <= cfg_data_i[9:0];
      end else if (cfg_idx_i == CFG_LONG) begin
        long_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= 1'b1;
        step_q      <= '0;
      end else if (advance) begin
        if (final_step) begin
          cur_valid_q <= 1'b0;
        end
        step_q <= step_q + 1'b1;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (stp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_entry_i;
    end
    if (advance) begin
      out_rs_q   <= rs_d;
      out_en_q   <= en_d;
      out_nib_q  <= nib_d;
      out_wait_q <= wait_d;
      out_last_q <= last_d;
    end
  end

  assign stp.valid      = out_valid_q;
  assign stp.reg_select = out_rs_q;
  assign stp.enable     = out_en_q;
  assign stp.nibble     = out_nib_q;
  assign stp.wait_us    = out_wait_q;
  assign stp.last       = out_last_q;

endmodule

`default_nettype wire
